// File: rtl/core/id_allocator_with_recycle_stack_core_assert.svh
// assertion helpers for the id allocator
`ifndef ID_ALLOCATOR_WITH_RECYCLE_STACK_CORE_ASSERT_SVH
`define ID_ALLOCATOR_WITH_RECYCLE_STACK_CORE_ASSERT_SVH

// same-cycle implication
`define IDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/idalloc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idalloc_pkg;

   localparam int MAX_IDS    = 1024;
   localparam int BIN_DEPTH  = 16;
   localparam int WORD_W     = 32;
   localparam int ID_W       = $clog2(MAX_IDS + 1);
   localparam int BIT_W      = $clog2(MAX_IDS);
   localparam int SEL_W      = $clog2(WORD_W);
   localparam int ADDR_W     = BIT_W - SEL_W;
   localparam int NUM_WORDS  = (MAX_IDS + WORD_W - 1) / WORD_W;
   localparam int CNT_W      = $clog2(BIN_DEPTH + 1);
   localparam int SP_W       = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int BIN_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef logic [ID_W-1:0]   id_type;
   typedef logic [BIT_W-1:0]  bit_idx_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SEL_W-1:0]  sel_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [BIN_W-1:0]  bin_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NOT_USED = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   // one read and one write port of the used bitmap
   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } bm_req_type;

   typedef struct packed {
      logic    refill;
      bin_type new_cap;
      logic    push;
      id_type  push_id;
      logic    pop;
   } stk_cmd_type;

   typedef struct packed {
      logic    found;
      sel_type sel;
   } fz_type;

   // stack capacity in use, saturated to the stack depth and the id space
   function automatic cnt_type clamp_cap(input bin_type b);
      logic [31:0] c;
      c = 32'(b);
      if (c > 32'(BIN_DEPTH)) c = 32'(BIN_DEPTH);
      if (c > 32'(MAX_IDS)) c = 32'(MAX_IDS);
      return CNT_W'(c);
   endfunction

   // bits of a word that lie beyond the id space read as used
   function automatic word_type pad_mask(input addr_type a);
      word_type    m;
      bit_idx_type idx;
      for (int b = 0; b < WORD_W; b++) begin
         idx  = {a, SEL_W'(b)};
         m[b] = (32'(idx) >= 32'(MAX_IDS));
      end
      return m;
   endfunction

   // lowest clear bit of a word
   function automatic fz_type first_zero(input word_type w);
      fz_type r;
      r = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!w[b]) begin
            r.found = 1'b1;
            r.sel   = SEL_W'(b);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/idalloc_bitmap.sv
`timescale 1ns / 1ps
`default_nettype none

// used bitmap, one word per row; rows never written read as all clear
module idalloc_bitmap
   import idalloc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire bm_req_type req,
   output word_type        rd_data
);

   word_type               mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]   row_valid_ff;
   word_type               rd_data_ff;
   logic                   rd_row_ok_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_row_ok_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            row_valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_row_ok_ff <= row_valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_row_ok_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/core/idalloc_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// recycle stack, last in first out
module idalloc_stack
   import idalloc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire stk_cmd_type cmd,
   output id_type           top_id,
   output cnt_type          count
);

   id_type               stk_ff [BIN_DEPTH];
   cnt_type              count_ff;
   cnt_type              cap_ff;
   cnt_type              refill_cap;
   cnt_type              cnt_dec;
   logic [SP_W-1:0]      sp_top;
   logic [SP_W-1:0]      sp_push;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      refill_cap = clamp_cap(cmd.new_cap);
      cnt_dec    = count_ff - CNT_W'(1);
      sp_top     = cnt_dec[SP_W-1:0];
      sp_push    = count_ff[SP_W-1:0];
      do_pop     = cmd.pop && (count_ff != '0);
      do_push    = cmd.push && (count_ff < cap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= '0;
      end else if (cmd.refill) begin
         count_ff <= refill_cap;
         cap_ff   <= refill_cap;
      end else if (do_pop) begin
         count_ff <= cnt_dec;
      end else if (do_push) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // refill puts 1 on top, capacity at the bottom
   always_ff @(posedge clock) begin
      if (cmd.refill) begin
         for (int k = 0; k < BIN_DEPTH; k++) begin
            stk_ff[k] <= ID_W'(32'(refill_cap) - 32'(k));
         end
      end else if (do_push) begin
         stk_ff[sp_push] <= cmd.push_id;
      end
   end

   assign top_id = stk_ff[sp_top];
   assign count  = count_ff;

endmodule

`default_nettype wire

// File: rtl/core/id_allocator_with_recycle_stack_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Identifier allocator. Hands out ids 1..1024 and takes them back. An allocate
// (req_tuser low) pops the recycle stack when it holds anything, else it scans
// the used bitmap for the lowest free id; with every id in use it answers id 0
// with status 2. A release (req_tuser high) of an id not in use answers status
// 1 and changes nothing; a good release clears the id and pushes it onto the
// stack if the stack has room. Every request gives exactly one response word.
// Writing csr_wdata sets the stack capacity (saturated to 16) and refills the
// stack with 1..capacity, 1 on top; the bitmap is untouched by that write.
// Sequence: a stack pop or a release of an id in 1..1024 passes S_RMW_RD, S_RMW_WR
// and S_DONE before the next accept; a release of an id outside that range
// goes straight to S_DONE; a bitmap scan stays in S_SCAN for each 32-bit
// bitmap word examined, bounded by the single bitmap read port that looks at
// one word a cycle. One request is in flight at a time; a finished response
// waits in the output register while the next request is taken, and a response
// that finds that register still full holds the block until the older word leaves.
module id_allocator_with_recycle_stack_core
   import idalloc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [10:0] release_id
   input  wire logic                  req_tuser,   // [0] opcode
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [10:0] given_id, [12:11] status
   // stack capacity register
   input  wire logic                  csr_wen,
   input  wire logic [BIN_W-1:0]      csr_wdata
);

   `include "id_allocator_with_recycle_stack_core_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_RMW_RD,
      S_RMW_WR,
      S_SCAN,
      S_DONE
   } state_type;

   state_type    state_ff;
   op_type       op_ff;
   bit_idx_type  bit_idx_ff;
   addr_type     scan_ptr_ff;
   id_type       given_ff;
   status_type   status_ff;
   logic         rsp_valid_ff;
   id_type       rsp_given_ff;
   status_type   rsp_status_ff;

   logic         accept;
   op_type       req_op;
   id_type       req_rid;
   logic         rid_bad;
   bm_req_type   bm_req;
   word_type     rd_word;
   word_type     scan_word;
   word_type     bit_onehot;
   word_type     scan_onehot;
   sel_type      sel_bit;
   logic         cur_bit;
   fz_type       fz;
   stk_cmd_type  stk_cmd;
   id_type       stk_top;
   cnt_type      stk_count;
   logic         scan_last;

   idalloc_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .req     (bm_req),
      .rd_data (rd_word)
   );

   idalloc_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stk_cmd),
      .top_id (stk_top),
      .count  (stk_count)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      req_op      = op_type'(req_tuser);
      req_rid     = req_tdata[ID_W-1:0];
      // id 0 and ids past the top of the space are never in use
      rid_bad     = (req_rid == '0) || (32'(req_rid) > 32'(MAX_IDS));
      sel_bit     = bit_idx_ff[SEL_W-1:0];
      cur_bit     = rd_word[sel_bit];
      bit_onehot  = word_type'(1) << sel_bit;
      scan_word   = rd_word | pad_mask(scan_ptr_ff);
      fz          = first_zero(scan_word);
      scan_onehot = word_type'(1) << fz.sel;
      scan_last   = (scan_ptr_ff == ADDR_W'(NUM_WORDS - 1));
   end

   // bitmap port: read-modify-write of one word, or a streaming scan
   always_comb begin
      bm_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            // first scan word goes out with the accept
            bm_req.rd_en   = accept && (req_op == OP_ALLOC) && (stk_count == '0);
            bm_req.rd_addr = '0;
         end
         S_RMW_RD: begin
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = bit_idx_ff[BIT_W-1:SEL_W];
         end
         S_RMW_WR: begin
            bm_req.wr_addr = bit_idx_ff[BIT_W-1:SEL_W];
            if (op_ff == OP_ALLOC) begin
               bm_req.wr_en   = 1'b1;
               bm_req.wr_data = rd_word | bit_onehot;
            end else begin
               bm_req.wr_en   = cur_bit;
               bm_req.wr_data = rd_word & ~bit_onehot;
            end
         end
         S_SCAN: begin
            // fetch the next word while this one is checked
            bm_req.rd_en   = !fz.found && !scan_last;
            bm_req.rd_addr = scan_ptr_ff + ADDR_W'(1);
            bm_req.wr_en   = fz.found;
            bm_req.wr_addr = scan_ptr_ff;
            bm_req.wr_data = rd_word | scan_onehot;
         end
         S_DONE: begin
            bm_req = '0;
         end
         default: begin
            bm_req = '0;
         end
      endcase
   end

   always_comb begin
      stk_cmd          = '0;
      stk_cmd.refill   = csr_wen;
      stk_cmd.new_cap  = csr_wdata;
      stk_cmd.pop      = accept && (req_op == OP_ALLOC) && (stk_count != '0);
      stk_cmd.push     = (state_ff == S_RMW_WR) && (op_ff == OP_RELEASE) && cur_bit;
      stk_cmd.push_id  = ID_W'(bit_idx_ff) + ID_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_DONE the output register is handled below
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff     <= req_op;
                  given_ff  <= '0;
                  status_ff <= ST_OK;
                  if (req_op == OP_ALLOC) begin
                     if (stk_count != '0) begin
                        // stack hit: mark the popped id as used
                        bit_idx_ff <= BIT_W'(stk_top - ID_W'(1));
                        given_ff   <= stk_top;
                        state_ff   <= S_RMW_RD;
                     end else begin
                        scan_ptr_ff <= '0;
                        state_ff    <= S_SCAN;
                     end
                  end else if (rid_bad) begin
                     status_ff <= ST_NOT_USED;
                     state_ff  <= S_DONE;
                  end else begin
                     bit_idx_ff <= BIT_W'(req_rid - ID_W'(1));
                     state_ff   <= S_RMW_RD;
                  end
               end
            end
            S_RMW_RD: begin
               state_ff <= S_RMW_WR;
            end
            S_RMW_WR: begin
               if ((op_ff == OP_RELEASE) && !cur_bit) begin
                  status_ff <= ST_NOT_USED;
               end
               state_ff <= S_DONE;
            end
            S_SCAN: begin
               if (fz.found) begin
                  given_ff <= ID_W'({scan_ptr_ff, fz.sel}) + ID_W'(1);
                  state_ff <= S_DONE;
               end else if (scan_last) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  scan_ptr_ff <= scan_ptr_ff + ADDR_W'(1);
               end
            end
            S_DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_given_ff  <= given_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_status_ff, rsp_given_ff});

   `IDA_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready,
      "request taken while a previous one is still in work")
   `IDA_ASSERT_NOW(a_bitmap_write_state, clock, reset, bm_req.wr_en,
      (state_ff == S_RMW_WR) || (state_ff == S_SCAN), "bitmap written outside an update step")
   `IDA_ASSERT_NOW(a_scan_stack_empty, clock, reset, state_ff == S_SCAN,
      stk_count == '0, "bitmap scan with ids left on the recycle stack")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// checks the id allocator against a behavioral copy of its bitmap and recycle stack
module tb_top;
   import idalloc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 40;     // a little more than the longest bitmap scan
   localparam int MIX_ITEMS   = 48;     // words per random phase
   localparam int DIR_ROWS    = 25;
   localparam int DUE_DEPTH   = 8;      // ring of owed responses, far above what can be owed

   // one expected response word
   typedef struct packed {
      id_type     given;
      status_type st;
   } grant_type;

   // one row of the directed table: a capacity write or a request word
   typedef struct packed {
      logic       is_cfg;
      bin_type    cfg_val;
      op_type     op;
      id_type     rid;
      logic       typed;    // expected answer written in the row
      id_type     exp_id;
      status_type exp_st;
   } dir_row_type;

   // dut ports; the inputs are all known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [10:0] release_id
   logic                  req_tuser  = 1'b0; // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [10:0] given_id, [12:11] status
   logic                  csr_wen    = 1'b0;
   logic [BIN_W-1:0]      csr_wdata  = '0;

   // allocator state as the checker sees it
   bit     id_taken [1:MAX_IDS];
   id_type recycle_ids [BIN_DEPTH];
   int     stack_fill;
   int     stack_cap;

   // responses still owed by the dut, oldest first
   grant_type due_list [DUE_DEPTH];
   int        due_wr;
   int        due_rd;

   int cycle_count;
   int mismatches;
   int words_sent;
   int words_checked;
   int full_answers;
   int not_used_answers;
   int cap_writes;
   int burst_left = 5;
   bit req_up;       // value last scheduled on req_tvalid

   // directed words: extremes, both opcodes, refill over used ids, clamp, releases out of range
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{1'b0, 5'd0,  OP_ALLOC,   11'd2047, 1'b1, 11'd1, ST_OK},       // lowest id after reset
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b1, 11'd2, ST_OK},
      '{1'b0, 5'd0,  OP_RELEASE, 11'd0,    1'b1, 11'd0, ST_NOT_USED}, // id zero never used
      '{1'b0, 5'd0,  OP_RELEASE, 11'd2047, 1'b1, 11'd0, ST_NOT_USED}, // far out of range
      '{1'b0, 5'd0,  OP_RELEASE, 11'd1025, 1'b1, 11'd0, ST_NOT_USED}, // just past the top
      '{1'b0, 5'd0,  OP_RELEASE, 11'd1024, 1'b1, 11'd0, ST_NOT_USED}, // top id, still free
      '{1'b0, 5'd0,  OP_RELEASE, 11'd2,    1'b1, 11'd0, ST_OK},
      '{1'b0, 5'd0,  OP_RELEASE, 11'd2,    1'b1, 11'd0, ST_NOT_USED}, // double release
      '{1'b0, 5'd0,  OP_ALLOC,   11'd1024, 1'b1, 11'd2, ST_OK},       // zero capacity, scan
      '{1'b1, 5'd3,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},       // refill 3,2,1
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b1, 11'd1, ST_OK},       // pops an id in use
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b1, 11'd2, ST_OK},
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b1, 11'd3, ST_OK},
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b1, 11'd4, ST_OK},       // stack empty, scan
      '{1'b0, 5'd0,  OP_RELEASE, 11'd3,    1'b1, 11'd0, ST_OK},
      '{1'b0, 5'd0,  OP_ALLOC,   11'd1,    1'b0, 11'd0, ST_OK},
      '{1'b1, 5'd31, OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},       // clamps to the depth
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},
      '{1'b0, 5'd0,  OP_RELEASE, 11'd4,    1'b0, 11'd0, ST_OK},
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},
      '{1'b1, 5'd0,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},       // empties the stack
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},
      '{1'b0, 5'd0,  OP_RELEASE, 11'd1,    1'b0, 11'd0, ST_OK},
      '{1'b1, 5'd16, OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK},       // full depth
      '{1'b0, 5'd0,  OP_ALLOC,   11'd0,    1'b0, 11'd0, ST_OK}
   };

   id_allocator_with_recycle_stack_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycle count, receiver stall pattern and the run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      // stall mode follows bits [9:8] of the cycle count: none, random, short periodic, long
      case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= ((cycle_count % 7) >= 3);
         default: rsp_tready <= ((cycle_count % 41) >= 24);
      endcase
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  due_wr - due_rd);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // new capacity: refill with capacity..1 so that id 1 sits on top
   function automatic void load_capacity(input bin_type val);
      int k;
      stack_cap = (int'(val) > BIN_DEPTH) ? BIN_DEPTH : int'(val);
      if (stack_cap > MAX_IDS) stack_cap = MAX_IDS;
      for (k = 0; k < stack_cap; k++) recycle_ids[k] = id_type'(stack_cap - k);
      stack_fill = stack_cap;
   endfunction

   // expected answer to one request word, advancing the tracked state
   function automatic void predict_grant(input op_type op, input id_type rid,
                                         output grant_type g);
      int k;
      g.given = '0;
      g.st    = ST_OK;
      if (op == OP_ALLOC) begin
         if (stack_fill > 0) begin
            // stack hit, the bit is set even if it already was
            stack_fill--;
            g.given = recycle_ids[stack_fill];
            id_taken[g.given] = 1'b1;
         end else begin
            // lowest free id, or pool exhausted
            g.st = ST_FULL;
            for (k = 1; k <= MAX_IDS; k++) begin
               if (!id_taken[k]) begin
                  id_taken[k] = 1'b1;
                  g.given     = id_type'(k);
                  g.st        = ST_OK;
                  break;
               end
            end
         end
      end else if (rid == 0 || rid > MAX_IDS || !id_taken[rid]) begin
         g.st = ST_NOT_USED;
      end else begin
         id_taken[rid] = 1'b0;
         if (stack_fill < stack_cap) begin
            recycle_ids[stack_fill] = rid;
            stack_fill++;
         end
      end
      if (g.st == ST_FULL) full_answers++;
      if (g.st == ST_NOT_USED) not_used_answers++;
   endfunction

   // some id in use, searched from a random start; zero when none
   function automatic id_type pick_taken_id();
      int start;
      int k;
      int id;
      start = $urandom_range(0, MAX_IDS - 1);
      for (k = 0; k < MAX_IDS; k++) begin
         id = (start + k) % MAX_IDS + 1;
         if (id_taken[id]) return id_type'(id);
      end
      return '0;
   endfunction

   // release target: mostly ids in use, some free or out of range
   function automatic id_type pick_release_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return pick_taken_id();
      if (r < 70) return id_type'($urandom_range(1, 40));
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return id_type'(MAX_IDS);
            2: return id_type'(MAX_IDS + 1);
            default: return '1;
         endcase
      end
      return id_type'($urandom_range(0, 2047));
   endfunction

   task automatic drop_req();
      if (req_up) begin
         req_tvalid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // wait until every expected response word has been taken
   task automatic drain_grants();
      drop_req();
      while (due_wr != due_rd) @(posedge clock);
   endtask

   // one request word through the handshake, then maybe a gap between bursts
   task automatic send_request(input op_type op, input id_type rid, input logic typed,
                               input id_type exp_id, input status_type exp_st);
      grant_type g;
      req_tvalid <= 1'b1;
      req_up = 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'(rid);
      do @(posedge clock); while (!req_tready);
      predict_grant(op, rid, g);
      if (typed) begin
         g.given = exp_id;
         g.st    = exp_st;
      end
      due_list[due_wr % DUE_DEPTH] = g;
      due_wr++;
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         drop_req();
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // now and then a long stretch with no idling
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // capacity write, only with the block idle
   task automatic write_capacity(input bin_type val);
      drain_grants();
      csr_wen   <= 1'b1;
      csr_wdata <= val;
      load_capacity(val);
      cap_writes++;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // random request with the given share of allocates
   task automatic send_random(input int alloc_pct);
      if ($urandom_range(0, 99) < alloc_pct)
         send_request(OP_ALLOC, id_type'($urandom_range(0, 2047)), 1'b0, '0, ST_OK);
      else
         send_request(OP_RELEASE, pick_release_id(), 1'b0, '0, ST_OK);
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_wr == due_rd) begin
            if (mismatches < 10)
               $display("stray response word %h with nothing outstanding", rsp_tdata);
            mismatches++;
         end else begin
            g = due_list[due_rd % DUE_DEPTH];
            due_rd++;
            words_checked++;
            if (rsp_tdata[ID_W-1:0] !== g.given ||
                rsp_tdata[ID_W+STATUS_W-1:ID_W] !== g.st) begin
               if (mismatches < 10)
                  $display("response %0d: expected id %0d status %0d, got id %0d status %0d",
                           words_checked, g.given, g.st, rsp_tdata[ID_W-1:0],
                           rsp_tdata[ID_W+STATUS_W-1:ID_W]);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      bin_type caps [7];
      int      p;
      int      n;
      caps = '{5'd5, 5'd16, 5'd0, 5'd31, 5'd1, 5'd9, bin_type'($urandom_range(0, 31))};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (n = 0; n < DIR_ROWS; n++) begin
         if (dir_rows[n].is_cfg)
            write_capacity(dir_rows[n].cfg_val);
         else
            send_request(dir_rows[n].op, dir_rows[n].rid, dir_rows[n].typed,
                         dir_rows[n].exp_id, dir_rows[n].exp_st);
      end

      // random phases, one capacity each
      for (p = 0; p < 7; p++) begin
         write_capacity(caps[p]);
         for (n = 0; n < MIX_ITEMS; n++) begin
            send_random(45);
            // sender holds off until the block has answered everything
            if ($urandom_range(0, 49) == 0) drain_grants();
         end
      end

      // refill over used ids: pops hand back ids in use, then scans again
      write_capacity(5'd16);
      for (n = 0; n < 20; n++)
         send_request(OP_ALLOC, id_type'($urandom_range(0, 2047)), 1'b0, '0, ST_OK);

      // drain mostly by releases, top ids included
      for (n = 0; n < 80; n++) send_random(25);

      drain_grants();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_wr != due_rd) begin
         $display("%0d expected responses never arrived", due_wr - due_rd);
         mismatches += due_wr - due_rd;
      end

      $display("sent %0d requests over %0d capacity writes; %0d pool-full, %0d not-in-use",
               words_sent, cap_writes, full_answers, not_used_answers);
      $display("checked %0d responses in %0d cycles, %0d mismatches", words_checked,
               cycle_count, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/idalloc_pkg.sv
rtl/core/idalloc_bitmap.sv
rtl/core/idalloc_stack.sv
rtl/core/id_allocator_with_recycle_stack_core.sv
tb/tb_top.sv
